>>> hdl/hgcd_pkg.sv
// Shared types, constants and elaboration-time CORDIC tables for the haversine distance pipeline
package hgcd_pkg;

  localparam int FRAC_BITS     = 30;
  localparam int CORDIC_STAGES = 32;

  localparam int ARG_W  = 36;
  localparam int XY_W   = 34;
  localparam int MAG_W  = 32;
  localparam int AMP_W  = FRAC_BITS + 1;
  localparam int REM_W  = FRAC_BITS + 3;
  localparam int DIST_W = 31;

  typedef logic signed [ARG_W-1:0] arg_t;
  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic [AMP_W-1:0]        amp_t;
  typedef logic [DIST_W-1:0]       dist_t;

  // trig arguments count 0.5e-7 degree
  localparam arg_t QUARTER_TURN = 36'sd1800000000;
  localparam arg_t HALF_TURN    = 36'sd3600000000;
  localparam arg_t FULL_TURN    = 36'sd7200000000;

  localparam logic [30:0] RAD_PER_HALFUNIT = 31'd2012227627;
  localparam int          RAD_SH           = 61 - FRAC_BITS;
  localparam int          Q62_SH           = 62 - FRAC_BITS;

  localparam logic [63:0] INV_GAIN_Q62   = 64'd2800459870029453049;
  localparam logic [63:0] QUARTER_PI_Q62 = 64'd3622009729038561421;

  localparam logic [29:0] EARTH_RADIUS_CM = 30'd637100000;
  localparam dist_t       DIST_MAX        = 31'd2001508680;
  localparam amp_t        FONE            = AMP_W'(64'd1 << FRAC_BITS);

  function automatic xy_t round_q62(input logic [63:0] v);
    return XY_W'((v + (64'd1 << (Q62_SH - 1))) >> Q62_SH);
  endfunction

  // magnitude of a Q-format product, rounded half up at the fraction point
  function automatic mag_t round_frac(input logic [63:0] p);
    return MAG_W'((p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
  endfunction

  function automatic mag_t mag_of(input xy_t v);
    return v[XY_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  // atan(2^-i) from the truncated alternating series, evaluated at elaboration
  function automatic xy_t atan_step(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          e;
    int          k;
    sum = 64'd0;
    k   = 0;
    if (i == 0) begin
      sum = QUARTER_PI_Q62;
    end else begin
      for (e = 62 - i; e >= 0; e = e - 2 * i) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        if (k[0]) sum = sum - term;
        else      sum = sum + term;
        k = k + 1;
      end
    end
    return round_q62(sum);
  endfunction

  localparam xy_t INV_GAIN = round_q62(INV_GAIN_Q62);

endpackage

>>> hdl/hgcd_sincos.sv
// Angle reduction, radian conversion and pipelined CORDIC rotation for sine and cosine
module hgcd_sincos (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hgcd_pkg::arg_t arg,
  output logic           out_valid,
  output hgcd_pkg::xy_t  sin_val,
  output hgcd_pkg::xy_t  cos_val
);

  localparam int N   = hgcd_pkg::CORDIC_STAGES;
  localparam int LAT = N + 5;

  logic [LAT-1:0]  vld_r;
  hgcd_pkg::arg_t  t_r;
  hgcd_pkg::arg_t  r_r;
  hgcd_pkg::arg_t  fold_val;
  logic            fold_neg;
  logic            fold_ncos;
  logic [30:0]     mag_r;
  logic            zneg3_r;
  logic            ncos3_r;
  logic [61:0]     prod_r;
  logic            zneg4_r;
  logic            ncos4_r;
  logic [61:0]     prod_rnd;
  logic [30:0]     zmag;
  hgcd_pkg::xy_t   x_r [0:N];
  hgcd_pkg::xy_t   y_r [0:N];
  hgcd_pkg::xy_t   z_r [0:N];
  logic            ncos_r [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // truncating remainder by a full turn, then into [-half, half]
  always_ff @(posedge clk) begin
    if (en) begin
      if (arg >= hgcd_pkg::FULL_TURN)       t_r <= arg - hgcd_pkg::FULL_TURN;
      else if (arg <= -hgcd_pkg::FULL_TURN) t_r <= arg + hgcd_pkg::FULL_TURN;
      else                                  t_r <= arg;
      if (t_r >= hgcd_pkg::HALF_TURN)       r_r <= t_r - hgcd_pkg::FULL_TURN;
      else if (t_r < -hgcd_pkg::HALF_TURN)  r_r <= t_r + hgcd_pkg::FULL_TURN;
      else                                  r_r <= t_r;
    end
  end

  // fold into [-quarter, quarter]; the cosine flips sign when folded
  always_comb begin
    fold_val  = r_r;
    fold_neg  = 1'b0;
    fold_ncos = 1'b0;
    if (r_r > hgcd_pkg::QUARTER_TURN) begin
      fold_val  = hgcd_pkg::HALF_TURN - r_r;
      fold_ncos = 1'b1;
    end else if (r_r < -hgcd_pkg::QUARTER_TURN) begin
      fold_val  = hgcd_pkg::HALF_TURN + r_r;
      fold_neg  = 1'b1;
      fold_ncos = 1'b1;
    end else if (r_r < 0) begin
      fold_val  = -r_r;
      fold_neg  = 1'b1;
    end
  end

  assign prod_rnd = prod_r + (62'd1 << (hgcd_pkg::RAD_SH - 1));
  assign zmag     = prod_rnd[hgcd_pkg::RAD_SH +: 31];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r     <= fold_val[30:0];
      zneg3_r   <= fold_neg;
      ncos3_r   <= fold_ncos;
      prod_r    <= mag_r * hgcd_pkg::RAD_PER_HALFUNIT;
      zneg4_r   <= zneg3_r;
      ncos4_r   <= ncos3_r;
      x_r[0]    <= hgcd_pkg::INV_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= zneg4_r ? -hgcd_pkg::XY_W'(zmag) : hgcd_pkg::XY_W'(zmag);
      ncos_r[0] <= ncos4_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam hgcd_pkg::xy_t ATAN = hgcd_pkg::atan_step(i);
    always_ff @(posedge clk) begin
      if (en) begin
        ncos_r[i+1] <= ncos_r[i];
        if (!z_r[i][hgcd_pkg::XY_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end
      end
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign sin_val   = y_r[N];
  assign cos_val   = ncos_r[N] ? -x_r[N] : x_r[N];

endmodule

>>> hdl/hgcd_hav_term.sv
// Haversine term a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2), clamped to [0,1]
module hgcd_hav_term (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hgcd_pkg::xy_t  s_lat,
  input  hgcd_pkg::xy_t  s_lon,
  input  hgcd_pkg::xy_t  c_start,
  input  hgcd_pkg::xy_t  c_end,
  output logic           out_valid,
  output hgcd_pkg::amp_t a_val,
  output hgcd_pkg::amp_t a_comp
);

  localparam int LAT = 7;

  logic [LAT-1:0]  vld_r;
  hgcd_pkg::mag_t  ms_lat_r, ms_lon_r, mc_s_r, mc_e_r;
  logic            neg1_r, neg2_r, neg3_r, neg4_r, neg5_r;
  logic [63:0]     p_lat_r, p_lon_r, p_cc_r, p4_r;
  hgcd_pkg::mag_t  q_lat_r, q_lon_r, q_cc_r, q_lat4_r, q_lat5_r, q4_r;
  logic signed [hgcd_pkg::MAG_W+1:0] sum;
  hgcd_pkg::amp_t  a6_r, a_r, ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // products in sign-magnitude, rounded half away from zero
  assign sum = neg5_r ?
      ($signed({2'b00, q_lat5_r}) - $signed({2'b00, q4_r})) :
      ($signed({2'b00, q_lat5_r}) + $signed({2'b00, q4_r}));

  always_ff @(posedge clk) begin
    if (en) begin
      ms_lat_r <= hgcd_pkg::mag_of(s_lat);
      ms_lon_r <= hgcd_pkg::mag_of(s_lon);
      mc_s_r   <= hgcd_pkg::mag_of(c_start);
      mc_e_r   <= hgcd_pkg::mag_of(c_end);
      neg1_r   <= c_start[hgcd_pkg::XY_W-1] ^ c_end[hgcd_pkg::XY_W-1];

      p_lat_r  <= ms_lat_r * ms_lat_r;
      p_lon_r  <= ms_lon_r * ms_lon_r;
      p_cc_r   <= mc_s_r * mc_e_r;
      neg2_r   <= neg1_r;

      q_lat_r  <= hgcd_pkg::round_frac(p_lat_r);
      q_lon_r  <= hgcd_pkg::round_frac(p_lon_r);
      q_cc_r   <= hgcd_pkg::round_frac(p_cc_r);
      neg3_r   <= neg2_r;

      p4_r     <= q_cc_r * q_lon_r;
      q_lat4_r <= q_lat_r;
      neg4_r   <= neg3_r;

      q4_r     <= hgcd_pkg::round_frac(p4_r);
      q_lat5_r <= q_lat4_r;
      neg5_r   <= neg4_r;

      if (sum < 0)
        a6_r <= '0;
      else if (sum > $signed({3'b000, hgcd_pkg::FONE}))
        a6_r <= hgcd_pkg::FONE;
      else
        a6_r <= hgcd_pkg::AMP_W'(sum);

      a_r  <= a6_r;
      ac_r <= hgcd_pkg::FONE - a6_r;
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign a_val     = a_r;
  assign a_comp    = ac_r;

endmodule

>>> hdl/hgcd_sqrt.sv
// Pipelined digit-by-digit square root of a Q fraction, one result bit per stage
module hgcd_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hgcd_pkg::amp_t radicand,
  output logic           out_valid,
  output hgcd_pkg::amp_t root
);

  localparam int D   = hgcd_pkg::AMP_W;
  localparam int LAT = D + 1;
  localparam int RW  = hgcd_pkg::REM_W;

  logic [LAT-1:0]  vld_r;
  hgcd_pkg::amp_t  v_r    [0:D];
  logic [RW-1:0]   rem_r  [0:D];
  hgcd_pkg::amp_t  root_r [0:D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]    <= radicand;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < D; j++) begin : g_digit
    localparam int K = D - 1 - j;
    logic [2*D-1:0] rad;
    logic [RW+1:0]  sh;
    logic [RW+1:0]  trial;

    // radicand is a scaled by 2^FRAC_BITS
    assign rad   = (2*D)'({v_r[j], {hgcd_pkg::FRAC_BITS{1'b0}}});
    assign sh    = {rem_r[j], rad[2*K+1 -: 2]};
    assign trial = (RW+2)'({root_r[j], 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[j+1] <= v_r[j];
        if (sh >= trial) begin
          rem_r[j+1]  <= RW'(sh - trial);
          root_r[j+1] <= {root_r[j][D-2:0], 1'b1};
        end else begin
          rem_r[j+1]  <= RW'(sh);
          root_r[j+1] <= {root_r[j][D-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign root      = root_r[D];

endmodule

>>> hdl/hgcd_atan.sv
// Pipelined CORDIC vectoring: angle of (x, y) for the central angle
module hgcd_atan (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hgcd_pkg::amp_t x_in,
  input  hgcd_pkg::amp_t y_in,
  output logic           out_valid,
  output hgcd_pkg::xy_t  angle
);

  localparam int N   = hgcd_pkg::CORDIC_STAGES;
  localparam int LAT = N + 1;

  logic [LAT-1:0] vld_r;
  hgcd_pkg::xy_t  x_r [0:N];
  hgcd_pkg::xy_t  y_r [0:N];
  hgcd_pkg::xy_t  z_r [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= hgcd_pkg::XY_W'(x_in);
      y_r[0] <= hgcd_pkg::XY_W'(y_in);
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam hgcd_pkg::xy_t ATAN = hgcd_pkg::atan_step(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][hgcd_pkg::XY_W-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end
      end
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign angle     = z_r[N];

endmodule

>>> hdl/haversine_great_circle_distance.sv
// Top level: great-circle distance between two positions, fully pipelined
//
//  Channel | Direction | Handshake             | Payload
//  in_     | slave     | in_tvalid / in_tready | in_tdata: two lat/lon pairs, 1e-7 degree
//  out_    | master    | out_tvalid/out_tready | out_tdata: distance in cm
//
// One transaction per cycle sustained while out_tready stays high.
// Latency is set by the two 32-stage CORDIC pipelines and the 31-stage square root.
// rst_n clears the valid bits only; datapath registers are not reset.
// A two-entry output/skid pair decouples the sides; the whole pipeline holds while
// the skid entry is occupied, so in_tready never depends on out_tready combinationally.
module haversine_great_circle_distance (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [30:0] start_latitude, [62:31] start_longitude, [93:63] end_latitude,
  // [125:94] end_longitude, [127:126] zero
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [30:0] distance_cm, [31] zero
  output logic [31:0]  out_tdata
);

  localparam int AW = hgcd_pkg::ARG_W;

  logic               pipe_adv;
  logic signed [30:0] lat_s, lat_e;
  logic signed [31:0] lon_s, lon_e;
  hgcd_pkg::arg_t     arg_dlat_r, arg_dlon_r, arg_lat_s_r, arg_lat_e_r;
  logic               v0_r;

  logic               sc_valid [0:3];
  hgcd_pkg::xy_t      s_lat, s_lon, c_start, c_end;
  hgcd_pkg::xy_t      sc_unused_c0, sc_unused_c1, sc_unused_s2, sc_unused_s3;
  logic               hav_in_valid, hav_valid;
  hgcd_pkg::amp_t     a_val, a_comp;
  logic               sq_a_valid, sq_c_valid;
  hgcd_pkg::amp_t     root_a, root_c;
  logic               at_valid;
  hgcd_pkg::xy_t      angle;

  logic               f1_v_r, f2_v_r;
  logic [31:0]        dz_r;
  logic [61:0]        dp_r;
  logic [61:0]        dp_rnd;
  logic [31:0]        dq;
  hgcd_pkg::dist_t    dist_nxt;
  logic               push;
  logic               out_valid_r, skid_valid_r;
  hgcd_pkg::dist_t    out_data_r, skid_data_r;

  assign pipe_adv  = ~skid_valid_r;
  assign in_tready = pipe_adv;

  assign lat_s = in_tdata[30:0];
  assign lon_s = in_tdata[62:31];
  assign lat_e = in_tdata[93:63];
  assign lon_e = in_tdata[125:94];

  // arguments in 0.5e-7 degree: differences give half angles, doubled latitudes full ones
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (pipe_adv) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      arg_dlat_r  <= AW'(lat_e) - AW'(lat_s);
      arg_dlon_r  <= AW'(lon_e) - AW'(lon_s);
      arg_lat_s_r <= AW'(lat_s) <<< 1;
      arg_lat_e_r <= AW'(lat_e) <<< 1;
    end
  end

  hgcd_sincos u_sc_dlat (
    .clk(clk), .rst_n(rst_n), .en(pipe_adv), .in_valid(v0_r), .arg(arg_dlat_r),
    .out_valid(sc_valid[0]), .sin_val(s_lat), .cos_val(sc_unused_c0)
  );

  hgcd_sincos u_sc_dlon (
    .clk(clk), .rst_n(rst_n), .en(pipe_adv), .in_valid(v0_r), .arg(arg_dlon_r),
    .out_valid(sc_valid[1]), .sin_val(s_lon), .cos_val(sc_unused_c1)
  );

  hgcd_sincos u_sc_lat_s (
    .clk(clk), .rst_n(rst_n), .en(pipe_adv), .in_valid(v0_r), .arg(arg_lat_s_r),
    .out_valid(sc_valid[2]), .sin_val(sc_unused_s2), .cos_val(c_start)
  );

  hgcd_sincos u_sc_lat_e (
    .clk(clk), .rst_n(rst_n), .en(pipe_adv), .in_valid(v0_r), .arg(arg_lat_e_r),
    .out_valid(sc_valid[3]), .sin_val(sc_unused_s3), .cos_val(c_end)
  );

  assign hav_in_valid = sc_valid[0] & sc_valid[1] & sc_valid[2] & sc_valid[3];

  hgcd_hav_term u_hav (
    .clk(clk), .rst_n(rst_n), .en(pipe_adv), .in_valid(hav_in_valid),
    .s_lat(s_lat), .s_lon(s_lon), .c_start(c_start), .c_end(c_end),
    .out_valid(hav_valid), .a_val(a_val), .a_comp(a_comp)
  );

  hgcd_sqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .en(pipe_adv), .in_valid(hav_valid),
    .radicand(a_val), .out_valid(sq_a_valid), .root(root_a)
  );

  hgcd_sqrt u_sqrt_c (
    .clk(clk), .rst_n(rst_n), .en(pipe_adv), .in_valid(hav_valid),
    .radicand(a_comp), .out_valid(sq_c_valid), .root(root_c)
  );

  hgcd_atan u_atan (
    .clk(clk), .rst_n(rst_n), .en(pipe_adv), .in_valid(sq_a_valid & sq_c_valid),
    .x_in(root_c), .y_in(root_a), .out_valid(at_valid), .angle(angle)
  );

  // negative angle (identical points) reads as zero; angle stays below 2^31
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (pipe_adv) begin
      f1_v_r <= at_valid;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      dz_r <= angle[hgcd_pkg::XY_W-1] ? 32'd0 : {angle[30:0], 1'b0};
      dp_r <= dz_r * hgcd_pkg::EARTH_RADIUS_CM;
    end
  end

  assign dp_rnd   = dp_r + (62'd1 << (hgcd_pkg::FRAC_BITS - 1));
  assign dq       = dp_rnd[hgcd_pkg::FRAC_BITS +: 32];
  assign dist_nxt = (dq > 32'(hgcd_pkg::DIST_MAX)) ? hgcd_pkg::DIST_MAX
                                                    : hgcd_pkg::DIST_W'(dq);

  assign push = f2_v_r & pipe_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r | push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : dist_nxt;
    end else if (push) begin
      skid_data_r <= dist_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule
